FILE: rtl/twrcd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// twrcd_pkg
// Types and constants for the ranging response checker: request and result
// payloads, config register indexes, status codes, frame layout.
// ----------------------------------------------------------------------------
package twrcd_pkg;

  typedef struct packed {
    logic [7:0]  rx_byte;
    logic        byte_last;
    logic [6:0]  frame_length;
    logic [39:0] poll_sent_time;
    logic [39:0] reply_heard_time;
  } req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [19:0] range_mm;
    logic [7:0]         sequence_number;
  } rsp_t;

  // config register indexes
  localparam logic [1:0] CFG_MY_ADDR   = 2'd0;
  localparam logic [1:0] CFG_PEER_ADDR = 2'd1;
  localparam logic [1:0] CFG_OFFSET    = 2'd2;

  localparam logic [15:0] MY_ADDR_RST   = 16'd17750;
  localparam logic [15:0] PEER_ADDR_RST = 16'd16727;

  // status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_LEN   = 2'd1;
  localparam logic [1:0] ST_HDR   = 2'd2;
  localparam logic [1:0] ST_RANGE = 2'd3;

  // fixed header bytes
  localparam logic [7:0] FC_LO   = 8'h41;
  localparam logic [7:0] FC_HI   = 8'h88;
  localparam logic [7:0] PAN_LO  = 8'hCA;
  localparam logic [7:0] PAN_HI  = 8'hDE;
  localparam logic [7:0] FN_RESP = 8'h10;

  // frame layout
  localparam int HDR_BYTES = 10;
  localparam int RCV_POS   = 10;
  localparam int REP_POS   = 15;
  localparam logic [6:0] WIRE_LEN = 7'd22;
  localparam logic [4:0] POS_MAX  = 5'd31;

  // round(2^24 * c * 1000 / (2 * 499.2 MHz * 128)), mm per tick in Q24
  localparam logic signed [26:0] K_Q24 = 27'sd39345565;

  // window limits and rounding mask in Q24 mm
  localparam logic signed [59:0] WIN_LOW_Q  = -60'sd16777216000;
  localparam logic signed [59:0] WIN_HIGH_Q = 60'sd8388608000000;
  localparam logic signed [59:0] FRAC_MASK  = 60'sd16777215;

endpackage
`default_nettype wire

FILE: rtl/twr_response_check_and_distance.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// twr_response_check_and_distance
// Checks a received ranging response frame byte by byte, captures the peer
// timestamps and turns the round-trip difference into a distance in mm.
//
//   channel | signals                               | dir | request / result
//   --------+---------------------------------------+-----+-----------------
//   in      | in_valid, in_stall, in_data           | in  | one frame byte
//   out     | out_valid, out_stall, out_data        | out | one per last byte
//   cfg     | cfg_valid, cfg_ready, cfg_index/data  | in  | register write
//
// One byte is accepted per cycle while in_stall is low. A last byte's result
// passes two subtract stages, the 33x27 multiply, the offset subtract, and
// the window/rounding stage into the output register.
// Stages advance independently; a stalled output holds only the stages
// behind it that are full. Reset (rst, synchronous) clears frame state,
// loads register defaults and empties the pipeline. cfg_ready is always 1.
// ----------------------------------------------------------------------------
module twr_response_check_and_distance (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire twrcd_pkg::req_t   in_data,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output twrcd_pkg::rsp_t        out_data,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [1:0]        cfg_index,
  input  wire logic [17:0]       cfg_data
);

  // config
  logic [15:0]        my_address;
  logic [15:0]        peer_address;
  logic signed [17:0] distance_offset_mm;

  // frame state (only the low 32 bits of the peer stamps matter)
  logic [4:0]  byte_position;
  logic        header_good;
  logic [7:0]  seen_sequence;
  logic [31:0] peer_receive_time;
  logic [31:0] peer_reply_time;

  // per-byte logic
  logic        accept;
  logic        cmp;
  logic [7:0]  want;
  logic        header_good_next;
  logic [7:0]  seq_next;
  logic [31:0] rcv_next;
  logic [31:0] rep_next;
  logic [1:0]  pre_status;

  // pipeline
  logic        s1_valid, s2_valid, s3_valid, s4_valid;
  logic        s1_ready, s2_ready, s3_ready, s4_ready, out_ready;
  logic [1:0]  s1_status, s2_status, s3_status, s4_status;
  logic [7:0]  s1_seq, s2_seq, s3_seq, s4_seq;
  logic [31:0] s1_ri, s1_rr;
  logic signed [32:0] s2_d;
  logic signed [59:0] s3_prod;
  logic signed [59:0] s4_v;
  logic signed [59:0] off_q;
  logic signed [59:0] v_adj;
  twrcd_pkg::rsp_t    out_next;

  assign cfg_ready = 1'b1;

  assign out_ready = !out_valid || !out_stall;
  assign s4_ready  = !s4_valid || out_ready;
  assign s3_ready  = !s3_valid || s4_ready;
  assign s2_ready  = !s2_valid || s3_ready;
  assign s1_ready  = !s1_valid || s2_ready;
  assign in_stall  = !s1_ready;
  assign accept    = in_valid && s1_ready;

  always_comb begin
    cmp  = 1'b1;
    want = 8'd0;
    case (byte_position)
      5'd0:    want = twrcd_pkg::FC_LO;
      5'd1:    want = twrcd_pkg::FC_HI;
      5'd3:    want = twrcd_pkg::PAN_LO;
      5'd4:    want = twrcd_pkg::PAN_HI;
      5'd5:    want = my_address[7:0];
      5'd6:    want = my_address[15:8];
      5'd7:    want = peer_address[7:0];
      5'd8:    want = peer_address[15:8];
      5'd9:    want = twrcd_pkg::FN_RESP;
      default: cmp  = 1'b0;
    endcase
    header_good_next = header_good && (!cmp || in_data.rx_byte == want);
    seq_next = (byte_position == 5'd2) ? in_data.rx_byte : seen_sequence;

    // byte 4 of each stamp falls outside mod 2^32 and is dropped
    rcv_next = peer_receive_time;
    rep_next = peer_reply_time;
    for (int i = 0; i < 4; i++) begin
      if (byte_position == 5'(twrcd_pkg::RCV_POS + i))
        rcv_next[8*i +: 8] = in_data.rx_byte;
      if (byte_position == 5'(twrcd_pkg::REP_POS + i))
        rep_next[8*i +: 8] = in_data.rx_byte;
    end

    if (in_data.frame_length != twrcd_pkg::WIRE_LEN)
      pre_status = twrcd_pkg::ST_LEN;
    else if (!header_good_next || byte_position < 5'(twrcd_pkg::HDR_BYTES - 1))
      pre_status = twrcd_pkg::ST_HDR;
    else
      pre_status = twrcd_pkg::ST_OK;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      my_address         <= twrcd_pkg::MY_ADDR_RST;
      peer_address       <= twrcd_pkg::PEER_ADDR_RST;
      distance_offset_mm <= 18'sd0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        twrcd_pkg::CFG_MY_ADDR:   my_address         <= cfg_data[15:0];
        twrcd_pkg::CFG_PEER_ADDR: peer_address       <= cfg_data[15:0];
        twrcd_pkg::CFG_OFFSET:    distance_offset_mm <= $signed(cfg_data);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (accept && in_data.byte_last)) begin
      byte_position     <= 5'd0;
      header_good       <= 1'b1;
      seen_sequence     <= 8'd0;
      peer_receive_time <= 32'd0;
      peer_reply_time   <= 32'd0;
    end else if (accept) begin
      if (byte_position != twrcd_pkg::POS_MAX)
        byte_position <= byte_position + 5'd1;
      header_good       <= header_good_next;
      seen_sequence     <= seq_next;
      peer_receive_time <= rcv_next;
      peer_reply_time   <= rep_next;
    end
  end

  // pipeline valids
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      s3_valid  <= 1'b0;
      s4_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s1_ready)  s1_valid  <= in_valid && in_data.byte_last;
      if (s2_ready)  s2_valid  <= s1_valid;
      if (s3_ready)  s3_valid  <= s2_valid;
      if (s4_ready)  s4_valid  <= s3_valid;
      if (out_ready) out_valid <= s4_valid;
    end
  end

  assign off_q = $signed({{18{distance_offset_mm[17]}}, distance_offset_mm, 24'd0});
  // truncate toward zero: bias negatives before the shift
  assign v_adj = s4_v + (s4_v[59] ? twrcd_pkg::FRAC_MASK : 60'sd0);

  always_comb begin
    out_next.sequence_number = s4_seq;
    out_next.range_mm        = 20'sd0;
    out_next.status          = s4_status;
    if (s4_status == twrcd_pkg::ST_OK) begin
      if (s4_v < twrcd_pkg::WIN_LOW_Q || s4_v > twrcd_pkg::WIN_HIGH_Q)
        out_next.status = twrcd_pkg::ST_RANGE;
      else
        out_next.range_mm = v_adj[43:24];
    end
  end

  // pipeline payload
  always_ff @(posedge clk) begin
    if (s1_ready) begin
      s1_status <= pre_status;
      s1_seq    <= seq_next;
      s1_ri     <= in_data.reply_heard_time[31:0] - in_data.poll_sent_time[31:0];
      s1_rr     <= rep_next - rcv_next;
    end
    if (s2_ready) begin
      s2_status <= s1_status;
      s2_seq    <= s1_seq;
      s2_d      <= $signed({1'b0, s1_ri}) - $signed({1'b0, s1_rr});
    end
    if (s3_ready) begin
      s3_status <= s2_status;
      s3_seq    <= s2_seq;
      s3_prod   <= s2_d * twrcd_pkg::K_Q24;
    end
    if (s4_ready) begin
      s4_status <= s3_status;
      s4_seq    <= s3_seq;
      s4_v      <= s3_prod - off_q;
    end
    if (out_ready) begin
      out_data <= out_next;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/twrcd_chk.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// twrcd_chk
// Port-level checks for the ranging response checker, bound to the top level.
// ----------------------------------------------------------------------------
module twrcd_chk (
  input wire logic             clk,
  input wire logic             rst,
  input wire logic             in_stall,
  input wire logic             out_valid,
  input wire logic             out_stall,
  input wire twrcd_pkg::rsp_t  out_data
);

  // a result held under stall stays put
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed or vanished while stalled");

  // distance only reported with an ok status
  a_dist_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status != twrcd_pkg::ST_OK |-> out_data.range_mm == 20'sd0)
    else $error("nonzero distance with failing status");

  // an ok distance lies inside the window
  a_dist_window: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status == twrcd_pkg::ST_OK
      |-> $signed(out_data.range_mm) >= -20'sd1000
       && $signed(out_data.range_mm) <= 20'sd500000)
    else $error("ok distance outside window");

  // with nothing waiting at the output the pipeline drains, so no input stall
  a_no_stall_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> !in_stall)
    else $error("input stalled with empty output");

endmodule

bind twr_response_check_and_distance twrcd_chk u_twrcd_chk (.*);
`default_nettype wire

FILE: verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the ranging response checker. Frames of bytes go in
// with random bursts and gaps: mostly well-formed responses with random
// sequence and timestamps, plus bad length, bad header, short, long and noise
// frames. A scoreboard predicts status, distance and sequence per last byte
// and compares every result. Register settings change between frames.
// ----------------------------------------------------------------------------

class ranging_scoreboard;
  localparam longint MM_PER_TICK_Q24 = 64'sd39345565;
  localparam longint Q24_ONE         = 64'sd16777216;
  localparam longint WIN_LOW_MM      = -64'sd1000;
  localparam longint WIN_HIGH_MM     = 64'sd500000;
  localparam int     BODY_END        = 20;

  logic [15:0] my_addr;
  logic [15:0] peer_addr;
  logic [17:0] offset_raw;

  int unsigned pos;
  bit          hdr_ok;
  logic [7:0]  seq;
  logic [39:0] rcv_ts;
  logic [39:0] rep_ts;

  twrcd_pkg::rsp_t expected_ranges[$];
  int              errors;

  function new();
    my_addr    = twrcd_pkg::MY_ADDR_RST;
    peer_addr  = twrcd_pkg::PEER_ADDR_RST;
    offset_raw = '0;
    errors     = 0;
    clear_frame();
  endfunction

  function void clear_frame();
    pos    = 0;
    hdr_ok = 1'b1;
    seq    = '0;
    rcv_ts = '0;
    rep_ts = '0;
  endfunction

  function void write_reg(logic [1:0] idx, logic [17:0] value);
    case (idx)
      twrcd_pkg::CFG_MY_ADDR:   my_addr = value[15:0];
      twrcd_pkg::CFG_PEER_ADDR: peer_addr = value[15:0];
      twrcd_pkg::CFG_OFFSET:    offset_raw = value;
      default: ;
    endcase
  endfunction

  function int pending();
    return expected_ranges.size();
  endfunction

  // Ticks at which the computed distance crosses each window limit.
  function void window_ticks(output longint lo, output longint hi);
    lo = ((WIN_LOW_MM + $signed(offset_raw)) * Q24_ONE) / MM_PER_TICK_Q24;
    hi = ((WIN_HIGH_MM + $signed(offset_raw)) * Q24_ONE) / MM_PER_TICK_Q24;
  endfunction

  // Accepted request: advance the frame and, on a last byte, predict the result.
  function void note_byte(twrcd_pkg::req_t r);
    int unsigned     p;
    logic [7:0]      want;
    bit              cmp;
    logic [31:0]     ri, rr;
    longint          d, off, v;
    twrcd_pkg::rsp_t e;
    p    = pos;
    cmp  = 1'b1;
    want = '0;
    case (p)
      0: want = twrcd_pkg::FC_LO;
      1: want = twrcd_pkg::FC_HI;
      2: begin
        seq = r.rx_byte;
        cmp = 1'b0;
      end
      3: want = twrcd_pkg::PAN_LO;
      4: want = twrcd_pkg::PAN_HI;
      5: want = my_addr[7:0];
      6: want = my_addr[15:8];
      7: want = peer_addr[7:0];
      8: want = peer_addr[15:8];
      9: want = twrcd_pkg::FN_RESP;
      default: begin
        cmp = 1'b0;
        if (p >= twrcd_pkg::RCV_POS && p < twrcd_pkg::REP_POS)
          rcv_ts[(p - twrcd_pkg::RCV_POS) * 8 +: 8] = r.rx_byte;
        else if (p >= twrcd_pkg::REP_POS && p < BODY_END)
          rep_ts[(p - twrcd_pkg::REP_POS) * 8 +: 8] = r.rx_byte;
      end
    endcase
    if (cmp && r.rx_byte != want)
      hdr_ok = 1'b0;
    if (pos < twrcd_pkg::POS_MAX)
      pos = p + 1;
    if (!r.byte_last)
      return;

    e.range_mm        = '0;
    e.sequence_number = seq;
    if (r.frame_length != twrcd_pkg::WIRE_LEN) begin
      e.status = twrcd_pkg::ST_LEN;
    end else if (!hdr_ok || p + 1 < twrcd_pkg::HDR_BYTES) begin
      e.status = twrcd_pkg::ST_HDR;
    end else begin
      ri  = r.reply_heard_time[31:0] - r.poll_sent_time[31:0];
      rr  = rep_ts[31:0] - rcv_ts[31:0];
      d   = longint'({32'd0, ri}) - longint'({32'd0, rr});
      off = $signed(offset_raw);
      v   = d * MM_PER_TICK_Q24 - off * Q24_ONE;
      if (v < WIN_LOW_MM * Q24_ONE || v > WIN_HIGH_MM * Q24_ONE) begin
        e.status = twrcd_pkg::ST_RANGE;
      end else begin
        e.status   = twrcd_pkg::ST_OK;
        e.range_mm = 20'(v / Q24_ONE);
      end
    end
    expected_ranges.push_back(e);
    clear_frame();
  endfunction

  function void check_result(twrcd_pkg::rsp_t got);
    twrcd_pkg::rsp_t e;
    if (expected_ranges.size() == 0) begin
      $display("%0t: unexpected result status %0d distance %0d seq %0d", $time,
               got.status, got.range_mm, got.sequence_number);
      errors++;
      return;
    end
    e = expected_ranges.pop_front();
    if (got.status !== e.status) begin
      $display("%0t: status expected %0d, got %0d", $time, e.status, got.status);
      errors++;
    end
    if (got.range_mm !== e.range_mm) begin
      $display("%0t: range_mm expected %0d, got %0d", $time, e.range_mm,
               got.range_mm);
      errors++;
    end
    if (got.sequence_number !== e.sequence_number) begin
      $display("%0t: sequence_number expected %0d, got %0d", $time,
               e.sequence_number, got.sequence_number);
      errors++;
    end
  endfunction
endclass

module tb_top;

  localparam int         ITEM_TARGET   = 750;
  localparam int         PHASE_ITEMS   = 100;
  localparam int         SETTLE_CYCLES = 10;
  localparam logic [1:0] CFG_UNUSED    = 2'd3;

  typedef enum int {FR_GOOD, FR_BAD_LEN, FR_BAD_HDR, FR_SHORT, FR_LONG, FR_NOISE}
    frame_kind_t;

  logic            clk = 1'b0;
  logic            rst = 1'b1;
  logic            in_valid = 1'b0;
  logic            in_stall;
  twrcd_pkg::req_t in_data = '0;
  logic            out_valid;
  logic            out_stall = 1'b0;
  twrcd_pkg::rsp_t out_data;
  logic            cfg_valid = 1'b0;
  logic            cfg_ready;
  logic [1:0]      cfg_index = '0;
  logic [17:0]     cfg_data = '0;

  ranging_scoreboard sb;
  int burst_left = 0;
  int items_sent = 0;
  int stall_mode = 0;
  int stall_count = 0;

  twr_response_check_and_distance u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    #1_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  // Receiver: stall mode is drawn anew each time stall_count runs out.
  always @(posedge clk) begin
    if (stall_count == 0) begin
      stall_mode  <= $urandom_range(0, 3);
      stall_count <= $urandom_range(20, 120);
    end else begin
      stall_count <= stall_count - 1;
    end
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      2: out_stall <= ($urandom_range(0, 9) < 7);
      default: out_stall <= (stall_count % 5 < 2);
    endcase
  end

  // Inputs only move at the rising edge, so the falling edge sees settled values.
  always @(negedge clk) begin
    if (!rst && out_valid === 1'b1 && !out_stall)
      sb.check_result(out_data);
  end

  task automatic send_req(input twrcd_pkg::req_t r);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_data  <= r;
    in_valid <= 1'b1;
    @(negedge clk);
    while (in_stall) begin
      @(posedge clk);
      @(negedge clk);
    end
    @(posedge clk);
    sb.note_byte(r);
    items_sent++;
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [17:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(negedge clk);
    while (!cfg_ready) begin
      @(posedge clk);
      @(negedge clk);
    end
    @(posedge clk);
    sb.write_reg(idx, value);
  endtask

  // Wait until every expected result is out and the pipeline has emptied.
  task automatic settle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic configure(input int ph);
    logic [15:0] my, peer;
    logic [17:0] off;
    my   = 16'($urandom);
    peer = 16'($urandom);
    off  = 18'($urandom_range(0, 200000) - 100000);
    case (ph)
      1: begin
        my   = 16'h0000;
        peer = 16'hFFFF;
        off  = 18'(-100000);
      end
      2: begin
        my   = 16'hFFFF;
        peer = 16'h0000;
        off  = 18'd100000;
      end
      3: off = 18'h20000;
      4: off = 18'h1FFFF;
      default: ;
    endcase
    // upper data bits are don't-care for the address registers
    write_reg(twrcd_pkg::CFG_MY_ADDR, {2'($urandom), my});
    write_reg(twrcd_pkg::CFG_PEER_ADDR, {2'($urandom), peer});
    write_reg(twrcd_pkg::CFG_OFFSET, off);
    if ($urandom_range(0, 2) == 0)
      write_reg(CFG_UNUSED, 18'($urandom));
    cfg_valid <= 1'b0;
  endtask

  function automatic twrcd_pkg::req_t filler(input logic [7:0] b);
    twrcd_pkg::req_t r;
    r.rx_byte          = b;
    r.byte_last        = 1'b0;
    r.frame_length     = 7'($urandom);
    r.poll_sent_time   = {8'($urandom), 32'($urandom)};
    r.reply_heard_time = {8'($urandom), 32'($urandom)};
    return r;
  endfunction

  function automatic frame_kind_t pick_kind();
    int n;
    n = $urandom_range(0, 99);
    if (n < 60) return FR_GOOD;
    if (n < 70) return FR_BAD_LEN;
    if (n < 80) return FR_BAD_HDR;
    if (n < 88) return FR_SHORT;
    if (n < 95) return FR_LONG;
    return FR_NOISE;
  endfunction

  task automatic send_frame(input frame_kind_t kind);
    logic [7:0]      body [0:19];
    logic [31:0]     rr, ri;
    logic [39:0]     rcv, rep, poll, heard;
    longint          lo, hi, d;
    int              last_pos, hp;
    logic [6:0]      flen;
    twrcd_pkg::req_t r;
    sb.window_ticks(lo, hi);
    case ($urandom_range(0, 9))
      0: d = lo + longint'($urandom_range(0, 6)) - 3;
      1: d = hi + longint'($urandom_range(0, 6)) - 3;
      2: d = longint'($signed($urandom));
      default: d = lo + longint'($urandom_range(0, 32'(hi - lo)));
    endcase
    rr    = ($urandom_range(0, 4) == 0) ? $urandom : $urandom_range(0, 32'h7FFF_FFFF);
    ri    = rr + d[31:0];
    rcv   = {8'($urandom), 32'($urandom)};
    rep   = rcv + {8'($urandom), rr};
    poll  = {8'($urandom), 32'($urandom)};
    heard = poll + {8'($urandom), ri};

    body[0] = twrcd_pkg::FC_LO;
    body[1] = twrcd_pkg::FC_HI;
    body[2] = 8'($urandom);
    body[3] = twrcd_pkg::PAN_LO;
    body[4] = twrcd_pkg::PAN_HI;
    body[5] = sb.my_addr[7:0];
    body[6] = sb.my_addr[15:8];
    body[7] = sb.peer_addr[7:0];
    body[8] = sb.peer_addr[15:8];
    body[9] = twrcd_pkg::FN_RESP;
    for (int i = 0; i < 5; i++) begin
      body[twrcd_pkg::RCV_POS + i] = rcv[i * 8 +: 8];
      body[twrcd_pkg::REP_POS + i] = rep[i * 8 +: 8];
    end

    last_pos = 19;
    flen     = twrcd_pkg::WIRE_LEN;
    case (kind)
      FR_BAD_LEN: begin
        do flen = 7'($urandom); while (flen == twrcd_pkg::WIRE_LEN);
      end
      FR_BAD_HDR: begin
        hp = $urandom_range(0, 8);
        if (hp >= 2) hp++;
        body[hp] = body[hp] ^ 8'($urandom_range(1, 255));
      end
      FR_SHORT: last_pos = $urandom_range(0, 18);
      FR_LONG:  last_pos = $urandom_range(20, 40);
      FR_NOISE: begin
        last_pos = $urandom_range(0, 30);
        for (int i = 0; i < 20; i++) body[i] = 8'($urandom);
      end
      default: ;
    endcase
    if (kind inside {FR_SHORT, FR_LONG, FR_NOISE} && $urandom_range(0, 3) == 0)
      flen = 7'($urandom);

    for (int p = 0; p <= last_pos; p++) begin
      r = filler(p < 20 ? body[p] : 8'($urandom));
      if (p == last_pos) begin
        r.byte_last        = 1'b1;
        r.frame_length     = flen;
        r.poll_sent_time   = poll;
        r.reply_heard_time = heard;
      end
      send_req(r);
    end
  endtask

  task automatic send_lone_byte(input logic [7:0] b, input logic [6:0] flen,
                                input logic [39:0] poll, input logic [39:0] heard);
    twrcd_pkg::req_t r;
    r.rx_byte          = b;
    r.byte_last        = 1'b1;
    r.frame_length     = flen;
    r.poll_sent_time   = poll;
    r.reply_heard_time = heard;
    send_req(r);
  endtask

  initial begin
    int ph;
    int phase_start;
    sb = new();
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // directed: one clean frame at reset settings, then one-byte frames
    send_frame(FR_GOOD);
    send_lone_byte(8'hFF, 7'h7F, {40{1'b1}}, '0);
    send_lone_byte(8'h00, twrcd_pkg::WIRE_LEN, '0, {40{1'b1}});
    settle();

    ph = 1;
    while (items_sent < ITEM_TARGET) begin
      configure(ph);
      phase_start = items_sent;
      while (items_sent - phase_start < PHASE_ITEMS && items_sent < ITEM_TARGET)
        send_frame(pick_kind());
      settle();
      ph++;
    end

    if (sb.errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/twrcd_pkg.sv
rtl/twr_response_check_and_distance.sv
rtl/twrcd_chk.sv
verif/tb_top.sv
